/* hdl/conv3x3_valid_stream_defines.svh */
// ---------------------------------------------------------------------------
// conv3x3_valid_stream assertion macros
// Shared concurrent assertion helpers, sampled on clk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_VALID_STREAM_DEFINES_SVH
`define CONV3X3_VALID_STREAM_DEFINES_SVH

// same-cycle implication
`define C3X3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C3X3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/c3x3_pkg.sv */
// ---------------------------------------------------------------------------
// c3x3_pkg
// Constants, register codes and shared types of the 3x3 convolution block.
// ---------------------------------------------------------------------------
package c3x3_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int KROW_W     = 24;
  localparam int COEF_W     = 8;
  localparam int IMG_W_BITS = 13;
  localparam int IMG_H_BITS = 16;
  localparam int OUT_W      = 20;
  localparam int TAPS       = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 13'd4096;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 16'd4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [LVL_W-1:0] level;
  } q_stat_t;

  typedef logic [KROW_W-1:0] krow_t;

endpackage

/* hdl/c3x3_if.sv */
// ---------------------------------------------------------------------------
// c3x3 stream interfaces
// Pixel input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface c3x3_pix_if #(
  parameter int PIXEL_BITS = c3x3_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3x3_res_if ();
  logic                               valid;
  logic                               ready;
  logic signed [c3x3_pkg::OUT_W-1:0]  filtered;
  logic                               frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

/* hdl/c3x3_fifo.sv */
// ---------------------------------------------------------------------------
// c3x3_fifo
// Short queue between front and back; holds one window per transaction.
// ---------------------------------------------------------------------------
`include "conv3x3_valid_stream_defines.svh"

module c3x3_fifo #(
  parameter int DATA_W = 73
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output c3x3_pkg::q_stat_t q_stat
);
  import c3x3_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r + LVL_W'(push) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data    = slot_r[rd_ptr_r];
  assign q_stat.level = level_r;

  `C3X3_ASSERT_NOW(a_no_overflow, push && !pop, level_r < LVL_W'(QUEUE_DEPTH), "queue overflow")
  `C3X3_ASSERT_NOW(a_no_underflow, pop, level_r != '0, "pop from empty queue")
  `C3X3_ASSERT_NEXT(a_level_track, push && !pop, level_r == $past(level_r) + LVL_W'(1),
                    "queue level lost a push")
endmodule

/* hdl/c3x3_front.sv */
// ---------------------------------------------------------------------------
// c3x3_front
// Raster counters, two line buffers and the 3x3 window; pushes full windows.
// ---------------------------------------------------------------------------
module c3x3_front #(
  parameter int MAX_WIDTH  = c3x3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c3x3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  c3x3_pix_if.sink                            in_pix,
  input  logic [c3x3_pkg::IMG_W_BITS-1:0]     image_width,
  input  logic [c3x3_pkg::IMG_H_BITS-1:0]     image_height,
  input  c3x3_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output logic [c3x3_pkg::TAPS*PIXEL_BITS:0]  push_data
);
  import c3x3_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > IMG_W_BITS) ? WW + 1 : IMG_W_BITS + 1;
  localparam int PB   = PIXEL_BITS;

  logic [PB-1:0] line_old_r [MAX_WIDTH];
  logic [PB-1:0] line_new_r [MAX_WIDTH];

  logic [CW-1:0]         col_r, col_nxt, col_cur;
  logic [IMG_H_BITS-1:0] row_r, row_nxt, row_cur;
  logic [WW-1:0]         eff_w, wm1;
  logic [IMG_H_BITS-1:0] eff_h, hm1;
  logic [CMPW-1:0]       iw_ext;
  logic                  acc, last_col;

  logic          s1_v_r, s1_prod_r, s1_fend_r, s1_fwd_r;
  logic [CW-1:0] s1_col_r;
  logic [PB-1:0] s1_px_r, rd_old_r, rd_new_r, fwd_old_r, fwd_new_r;
  logic [PB-1:0] cur_old, cur_new;
  logic [PB-1:0] win_r [TAPS];
  logic [PB-1:0] win_nxt [TAPS];

  assign iw_ext = CMPW'(image_width);

  always_comb begin
    if (iw_ext < CMPW'(3)) begin
      eff_w = WW'(3);
    end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(iw_ext);
    end
    eff_h = (image_height < IMG_H_BITS'(3)) ? IMG_H_BITS'(3) : image_height;
    wm1   = eff_w - WW'(1);
    hm1   = eff_h - IMG_H_BITS'(1);
  end

  assign acc     = in_pix.valid && in_pix.ready;
  assign col_cur = in_pix.frame_start ? '0 : col_r;
  assign row_cur = in_pix.frame_start ? '0 : row_r;
  assign last_col = WW'(col_cur) >= wm1;

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = (row_cur >= hm1) ? '0 : row_cur + IMG_H_BITS'(1);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  assign cur_old = s1_fwd_r ? fwd_old_r : rd_old_r;
  assign cur_new = s1_fwd_r ? fwd_new_r : rd_new_r;

  // line buffers: read on acceptance, written back in the following cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_old_r <= line_old_r[col_cur];
      rd_new_r <= line_new_r[col_cur];
    end
    if (s1_v_r) begin
      line_old_r[s1_col_r] <= cur_new;
      line_new_r[s1_col_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= col_cur;
      s1_px_r   <= in_pix.pixel;
      s1_prod_r <= (row_cur >= IMG_H_BITS'(2)) && (col_cur >= CW'(2));
      s1_fend_r <= (row_cur == hm1) && (WW'(col_cur) == wm1);
      s1_fwd_r  <= s1_v_r && (s1_col_r == col_cur);
      fwd_old_r <= cur_new;
      fwd_new_r <= s1_px_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3 + 1];
      win_nxt[r*3 + 1] = win_r[r*3 + 2];
    end
    win_nxt[2] = cur_old;
    win_nxt[5] = cur_new;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      push_data[k*PB +: PB] = win_nxt[k];
    end
    push_data[TAPS*PB] = s1_fend_r;
  end

  assign push = s1_v_r && s1_prod_r;

  // room for this transaction once the one in flight has landed
  assign in_pix.ready = ((LVL_W + 1)'(q_stat.level) + (LVL_W + 1)'(push))
                        < (LVL_W + 1)'(QUEUE_DEPTH);
endmodule

/* hdl/c3x3_back.sv */
// ---------------------------------------------------------------------------
// c3x3_back
// Multiply-accumulate pipeline: products, row sums, window sum, output reg.
// ---------------------------------------------------------------------------
module c3x3_back #(
  parameter int PIXEL_BITS = c3x3_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  c3x3_pkg::krow_t                    kernel_row_top,
  input  c3x3_pkg::krow_t                    kernel_row_middle,
  input  c3x3_pkg::krow_t                    kernel_row_bottom,
  input  c3x3_pkg::q_stat_t                  q_stat,
  input  logic [c3x3_pkg::TAPS*PIXEL_BITS:0] head_data,
  output logic                               pop,
  c3x3_res_if.source                         out_res
);
  import c3x3_pkg::*;

  localparam int PB   = PIXEL_BITS;
  localparam int PW   = PB + 1 + COEF_W;
  localparam int ACCW = (PW > OUT_W) ? PW : OUT_W;

  logic                      adv, q_has;
  logic                      p_v_r, s_v_r, o_v_r;
  logic                      p_fend_r, s_fend_r, o_fend_r;
  logic signed [COEF_W-1:0]  coef [TAPS];
  logic signed [PW-1:0]      prod_r [TAPS];
  logic signed [ACCW-1:0]    rsum_r [3];
  logic signed [ACCW-1:0]    total;
  logic signed [OUT_W-1:0]   o_sum_r;
  krow_t                     krow [3];

  assign krow[0] = kernel_row_top;
  assign krow[1] = kernel_row_middle;
  assign krow[2] = kernel_row_bottom;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      coef[k] = $signed(krow[k / 3][(k % 3)*COEF_W +: COEF_W]);
    end
  end

  assign q_has = q_stat.level != '0;
  assign adv   = !o_v_r || out_res.ready;
  assign pop   = adv && q_has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= q_has;
      s_v_r <= p_v_r;
      o_v_r <= s_v_r;
    end
  end

  assign total = rsum_r[0] + rsum_r[1] + rsum_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= $signed({1'b0, head_data[k*PB +: PB]}) * coef[k];
      end
      p_fend_r <= head_data[TAPS*PB];
      for (int r = 0; r < 3; r++) begin
        rsum_r[r] <= ACCW'(prod_r[r*3]) + ACCW'(prod_r[r*3 + 1]) + ACCW'(prod_r[r*3 + 2]);
      end
      s_fend_r <= p_fend_r;
      o_sum_r  <= total[OUT_W-1:0];
      o_fend_r <= s_fend_r;
    end
  end

  assign out_res.valid     = o_v_r;
  assign out_res.filtered  = o_sum_r;
  assign out_res.frame_end = o_fend_r;
endmodule

/* hdl/conv3x3_valid_stream.sv */
// ---------------------------------------------------------------------------
// conv3x3_valid_stream
// 3x3 convolution over a raster pixel stream, no padding. Pixels are taken
// one per clock while the queue has room: the front reads both line buffers
// at the pixel's column when the transaction is accepted and writes them back
// in the following cycle, so each buffer sees one read and one write per
// clock. A result (window sum times the unflipped kernel, exact, 20-bit
// two's complement) passes the front stage, the queue and the back pipeline
// after the pixel that completes its window is accepted, later while the
// output stalls, one per input position with row and column both at least
// 2; frame_end marks the last result of a frame. A four-entry queue parts
// the front from the multiply pipeline, so input stays open while results
// wait; it closes only when the queue fills. Line buffers are not cleared:
// columns must be written before they are read. Configuration (kernel rows,
// width, height) must be written only while the block is idle; not enforced.
// ---------------------------------------------------------------------------
module conv3x3_valid_stream #(
  parameter int MAX_WIDTH  = c3x3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c3x3_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  c3x3_pix_if.sink                           in_pix,
  c3x3_res_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [c3x3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3x3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import c3x3_pkg::*;

  localparam int QW = TAPS * PIXEL_BITS + 1;

  krow_t                  ktop_r, kmid_r, kbot_r;
  logic [IMG_W_BITS-1:0]  img_w_r;
  logic [IMG_H_BITS-1:0]  img_h_r;

  logic          push, pop;
  logic [QW-1:0] push_data, head_data;
  q_stat_t       q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r  <= '0;
      kmid_r  <= '0;
      kbot_r  <= '0;
      img_w_r <= IMG_W_RESET;
      img_h_r <= IMG_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_TOP:    ktop_r  <= cfg_wdata[KROW_W-1:0];
        CFG_KERNEL_MIDDLE: kmid_r  <= cfg_wdata[KROW_W-1:0];
        CFG_KERNEL_BOTTOM: kbot_r  <= cfg_wdata[KROW_W-1:0];
        CFG_IMAGE_WIDTH:   img_w_r <= cfg_wdata[IMG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  c3x3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_pix       (in_pix),
    .image_width  (img_w_r),
    .image_height (img_h_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  c3x3_fifo #(
    .DATA_W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_stat    (q_stat)
  );

  c3x3_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .kernel_row_top    (ktop_r),
    .kernel_row_middle (kmid_r),
    .kernel_row_bottom (kbot_r),
    .q_stat            (q_stat),
    .head_data         (head_data),
    .pop               (pop),
    .out_res           (out_res)
  );
endmodule
